// File: design/alux_pkg.sv
package alux_pkg;

    localparam int COUNT_W     = 16;
    localparam int LUX_W       = 21;
    localparam int REGION_W    = 3;
    localparam int COEF_FRAC   = 32;
    localparam int COEF_W      = 28;
    localparam int POW_W       = 24;
    localparam int PROD_W      = 44;
    localparam int M_W         = 32;
    localparam int M_SHIFT     = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LUX_W-1:0] LUX_MAX = '1;

    localparam logic [COEF_W-1:0] K1A = COEF_W'(((64'd304 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K1B = COEF_W'(((64'd62 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K2A = COEF_W'(((64'd224 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K2B = COEF_W'(((64'd31 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K3A = COEF_W'(((64'd128 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K3B = COEF_W'(((64'd153 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K4A = COEF_W'(((64'd146 << 32) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] K4B = COEF_W'(((64'd112 << 32) + 64'd50000) / 64'd100000);

    typedef enum logic [REGION_W-1:0] {
        REGION_NONE = 3'd0,
        REGION_1    = 3'd1,
        REGION_2    = 3'd2,
        REGION_3    = 3'd3,
        REGION_4    = 3'd4
    } region_t;

    typedef struct packed {
        logic [COUNT_W-1:0] broadband_count;
        logic [COUNT_W-1:0] infrared_count;
        region_t            region;
    } item_t;

    // largest y with y^5 * (2*depth)^7 <= i^7 * 2^(5*POW_W)
    function automatic logic [POW_W-1:0] pow_entry(input int unsigned depth,
                                                   input int unsigned i);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] span;
        logic [255:0] iv;
        logic [POW_W:0] lo;
        logic [POW_W:0] hi;
        logic [POW_W:0] mid;
        rhs  = 256'd1;
        iv   = 256'(i);
        span = 256'(2 * depth);
        for (int k = 0; k < 7; k++)
        begin
            rhs = rhs * iv;
        end
        rhs = rhs << (5 * POW_W);
        lo  = '0;
        hi  = (POW_W+1)'((1 << POW_W) - 1);
        for (int s = 0; s <= POW_W; s++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + (POW_W+1)'(1)) >> 1);
                lhs = 256'd1;
                for (int k = 0; k < 5; k++)
                begin
                    lhs = lhs * 256'(mid);
                end
                for (int k = 0; k < 7; k++)
                begin
                    lhs = lhs * span;
                end
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - (POW_W+1)'(1);
                end
            end
        end
        return lo[POW_W-1:0];
    endfunction

endpackage

// File: design/alux_if.sv
interface alux_in_if import alux_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count, input ready);
    modport sink (input valid, input broadband_count, input infrared_count, output ready);
    modport monitor (input valid, input broadband_count, input infrared_count, input ready);
endinterface

interface alux_out_if import alux_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LUX_W-1:0]    lux_value;
    logic [REGION_W-1:0] region;

    modport source (output valid, output lux_value, output region, input ready);
    modport sink (input valid, input lux_value, input region, output ready);
    modport monitor (input valid, input lux_value, input region, input ready);
endinterface

// File: design/alux_front.sv
module alux_front import alux_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    alux_in_if.sink    sample,
    output item_t      item,
    output logic       item_valid,
    input  logic       item_ready
);

    logic [23:0] c0;
    logic [23:0] c1;
    region_t     region_next;
    item_t       item_reg;
    logic        valid_reg;
    logic        take;

    assign c0 = 24'(sample.broadband_count);
    assign c1 = 24'(sample.infrared_count);

    always_comb
    begin
        region_next = REGION_NONE;
        if (c0 != '0 && c1 != '0)
        begin
            if ((c1 << 1) <= c0)
                region_next = REGION_1;
            else if (24'd100 * c1 <= 24'd61 * c0)
                region_next = REGION_2;
            else if (24'd5 * c1 <= 24'd4 * c0)
                region_next = REGION_3;
            else if (24'd10 * c1 <= 24'd13 * c0)
                region_next = REGION_4;
        end
    end

    assign sample.ready = !valid_reg || item_ready;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (sample.ready)
            valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.broadband_count <= sample.broadband_count;
            item_reg.infrared_count  <= sample.infrared_count;
            item_reg.region          <= region_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: design/alux_queue.sv
module alux_queue import alux_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t in_item,
    input  logic  in_valid,
    output logic  in_ready,
    output item_t out_item,
    output logic  out_valid,
    input  logic  out_ready
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end

endmodule

// File: design/alux_back.sv
module alux_back import alux_pkg::*;
#(
    parameter int POWER_TABLE_DEPTH = 256,
    parameter int LUX_FRACTION_BITS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  logic      item_valid,
    output logic      item_ready,
    alux_out_if.source result
);

    localparam int IDX_W = $clog2(POWER_TABLE_DEPTH + 1);
    localparam int QW    = 16 + IDX_W;
    localparam int SPAN  = 2 * POWER_TABLE_DEPTH;
    localparam int NUM_W = COUNT_W + $clog2(SPAN + 1) + 16;
    localparam int SHIFT = COEF_FRAC - LUX_FRACTION_BITS;
    localparam int NST   = QW + 7;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POWER_TABLE_DEPTH);
    localparam logic [PROD_W:0]  HALF     = (PROD_W+1)'(1) << (SHIFT - 1);

    typedef struct packed {
        region_t             region;
        logic [COUNT_W-1:0]  c0;
        logic [PROD_W-1:0]   a;
        logic [PROD_W-1:0]   bl;
        logic [M_W-1:0]      m;
    } side_t;

    logic [NST-1:0]      vld_reg;
    logic                adv;

    logic [POW_W-1:0]    pow_rom [0:POWER_TABLE_DEPTH];

    logic [COEF_W-1:0]   ka;
    logic [COEF_W-1:0]   kb;
    logic [NUM_W-1:0]    num_next;
    side_t               sd_next;

    logic [COUNT_W-1:0]  rem_reg [0:QW];
    logic [QW-1:0]       nlo_reg [0:QW];
    logic [QW-1:0]       q_reg   [0:QW];
    side_t               sd_reg  [0:QW];

    logic [IDX_W-1:0]    idx_next;
    logic [15:0]         frac_next;
    logic [POW_W-1:0]    t0_next;
    logic [POW_W-1:0]    t1_next;

    logic [POW_W-1:0]    t0_reg;
    logic [POW_W-1:0]    dt_reg;
    logic [15:0]         frac_reg;
    side_t               sd_t_reg;

    logic [POW_W-1:0]    t0m_reg;
    logic [POW_W-1:0]    fp_reg;
    side_t               sd_m_reg;

    logic [POW_W-1:0]    p_reg;
    side_t               sd_p_reg;

    logic [PROD_W-1:0]   b1_reg;
    side_t               sd_q_reg;

    logic [PROD_W-1:0]   b_next;
    logic [PROD_W-1:0]   diff_reg;
    region_t             region_r_reg;

    logic [PROD_W:0]     rnd_next;
    logic [LUX_W-1:0]    lux_reg;
    region_t             region_o_reg;

    for (genvar g = 0; g <= POWER_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [POW_W-1:0] ENTRY = pow_entry(POWER_TABLE_DEPTH, g);
        assign pow_rom[g] = ENTRY;
    end

    assign adv        = !vld_reg[NST-1] || result.ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], item_valid};
    end

    always_comb
    begin
        unique case (item.region)
            REGION_1:
            begin
                ka = K1A;
                kb = '0;
            end
            REGION_2:
            begin
                ka = K2A;
                kb = K2B;
            end
            REGION_3:
            begin
                ka = K3A;
                kb = K3B;
            end
            REGION_4:
            begin
                ka = K4A;
                kb = K4B;
            end
            default:
            begin
                ka = '0;
                kb = '0;
            end
        endcase
    end

    assign num_next      = (NUM_W'(SPAN) * NUM_W'(item.infrared_count)) << 16;
    assign sd_next.region = item.region;
    assign sd_next.c0     = item.broadband_count;
    assign sd_next.a      = PROD_W'(ka) * PROD_W'(item.broadband_count);
    assign sd_next.bl     = PROD_W'(kb) * PROD_W'(item.infrared_count);
    assign sd_next.m      = M_W'((PROD_W'(K1B) * PROD_W'(item.broadband_count)) >> M_SHIFT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= COUNT_W'(num_next >> QW);
            nlo_reg[0] <= num_next[QW-1:0];
            q_reg[0]   <= '0;
            sd_reg[0]  <= sd_next;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        logic [COUNT_W:0]   r2;
        logic               ge;
        logic [COUNT_W-1:0] rem_next;

        assign r2       = {rem_reg[j-1], nlo_reg[j-1][QW-1]};
        assign ge       = r2 >= {1'b0, sd_reg[j-1].c0};
        assign rem_next = ge ? COUNT_W'(r2 - {1'b0, sd_reg[j-1].c0}) : r2[COUNT_W-1:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= rem_next;
                nlo_reg[j] <= nlo_reg[j-1] << 1;
                q_reg[j]   <= {q_reg[j-1][QW-2:0], ge};
                sd_reg[j]  <= sd_reg[j-1];
            end
        end
    end

    always_comb
    begin
        idx_next  = q_reg[QW][QW-1:16];
        frac_next = q_reg[QW][15:0];
        if (idx_next >= IDX_LAST)
        begin
            idx_next  = IDX_LAST;
            frac_next = '0;
        end
        t0_next = pow_rom[idx_next];
        t1_next = (idx_next < IDX_LAST) ? pow_rom[idx_next + IDX_W'(1)] : t0_next;
    end

    assign b_next   = (sd_q_reg.region == REGION_1) ? b1_reg : sd_q_reg.bl;
    assign rnd_next = ((PROD_W+1)'(diff_reg) + HALF) >> SHIFT;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg   <= t0_next;
            dt_reg   <= t1_next - t0_next;
            frac_reg <= frac_next;
            sd_t_reg <= sd_reg[QW];

            t0m_reg  <= t0_reg;
            fp_reg   <= POW_W'(((POW_W+16)'(dt_reg) * (POW_W+16)'(frac_reg)) >> 16);
            sd_m_reg <= sd_t_reg;

            p_reg    <= t0m_reg + fp_reg;
            sd_p_reg <= sd_m_reg;

            b1_reg   <= PROD_W'(((M_W+POW_W)'(sd_p_reg.m) * (M_W+POW_W)'(p_reg)) >> M_SHIFT);
            sd_q_reg <= sd_p_reg;

            diff_reg     <= (sd_q_reg.a > b_next) ? sd_q_reg.a - b_next : '0;
            region_r_reg <= sd_q_reg.region;

            lux_reg      <= (rnd_next > (PROD_W+1)'(LUX_MAX)) ? LUX_MAX : LUX_W'(rnd_next);
            region_o_reg <= region_r_reg;
        end
    end

    assign result.valid     = vld_reg[NST-1];
    assign result.lux_value = lux_reg;
    assign result.region    = region_o_reg;

endmodule

// File: design/ambient_light_lux_from_two_channels.sv
// Lux from a broadband/infrared count pair. One request is taken per clock and
// one result leaves per clock when the output is not stalled. A request passes
// through the classifier, the four-entry queue and the arithmetic pipeline, in
// that order. The pipeline depth is set by the ratio divider, which resolves
// one quotient bit per stage. lux_value carries LUX_FRACTION_BITS fraction bits
// and saturates; region is 0 when no band applies.
module ambient_light_lux_from_two_channels import alux_pkg::*;
#(
    parameter int POWER_TABLE_DEPTH = 256,
    parameter int LUX_FRACTION_BITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    alux_in_if.sink    sample,
    alux_out_if.source result
);

    item_t fr_item;
    logic  fr_valid;
    logic  fr_ready;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    alux_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .item       (fr_item),
        .item_valid (fr_valid),
        .item_ready (fr_ready)
    );

    alux_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (fr_item),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .out_item  (q_item),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    alux_back #(
        .POWER_TABLE_DEPTH (POWER_TABLE_DEPTH),
        .LUX_FRACTION_BITS (LUX_FRACTION_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .result     (result)
    );

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.region == REGION_NONE |-> result.lux_value == '0)
        else $error("lux nonzero with no band");

    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.region <= REGION_4)
        else $error("band code out of range");

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid && !fr_ready |=> fr_valid && $stable(fr_item))
        else $error("classified request dropped while queue full");

endmodule

// File: tb/lux_checker.sv
`timescale 1ns / 1ps

module lux_checker import alux_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    alux_in_if.monitor  sample,
    alux_out_if.monitor result,
    output int         errors,
    output int         pending,
    output int         accepted
);

    localparam int DEPTH = 256;
    localparam int FRAC  = 10;

    typedef struct {
        logic [LUX_W-1:0] lux;
        region_t          band;
    } lux_expect_t;

    lux_expect_t      lux_expected[$];
    logic [23:0]      power_table[0:DEPTH];
    int               band_hits[5];

    function automatic logic [63:0] coef(input longint n, input longint d);
        return ((64'(n) << 32) + 64'(d / 2)) / 64'(d);
    endfunction

    // largest y with y^5 * (2D)^7 <= i^7 * 2^120
    function automatic logic [23:0] root_entry(input int unsigned i);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [24:0]  lo;
        logic [24:0]  hi;
        logic [24:0]  mid;
        rhs = 256'(i) ** 7;
        rhs = rhs << 120;
        lo = '0;
        hi = 25'((1 << 24) - 1);
        while (lo < hi)
        begin
            mid = lo + ((hi - lo + 25'd1) >> 1);
            lhs = (256'(mid) ** 5) * (256'(2 * DEPTH) ** 7);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 25'd1;
        end
        return lo[23:0];
    endfunction

    function automatic lux_expect_t lux_of(input logic [15:0] c0, input logic [15:0] c1);
        lux_expect_t  r;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  pos;
        logic [63:0]  idx;
        logic [63:0]  f;
        logic [63:0]  t0;
        logic [63:0]  t1;
        logic [63:0]  p;
        logic [63:0]  m;
        logic [63:0]  v;
        logic [63:0]  x0;
        logic [63:0]  x1;
        x0 = 64'(c0);
        x1 = 64'(c1);
        a = '0;
        b = '0;
        r.band = REGION_NONE;
        if (c0 != 0 && c1 != 0)
        begin
            if (2 * x1 <= x0)
                r.band = REGION_1;
            else if (100 * x1 <= 61 * x0)
                r.band = REGION_2;
            else if (5 * x1 <= 4 * x0)
                r.band = REGION_3;
            else if (10 * x1 <= 13 * x0)
                r.band = REGION_4;
        end
        case (r.band)
            REGION_1:
            begin
                pos = ((64'(2 * DEPTH) * x1) << 16) / x0;
                idx = pos >> 16;
                f = pos & 64'hFFFF;
                if (idx >= 64'(DEPTH))
                begin
                    idx = 64'(DEPTH);
                    f = '0;
                end
                t0 = 64'(power_table[idx]);
                t1 = (f != 0) ? 64'(power_table[idx + 64'd1]) : t0;
                p = t0 + (((t1 - t0) * f) >> 16);
                a = coef(304, 10000) * x0;
                m = (coef(62, 1000) * x0) >> 12;
                b = (m * p) >> 12;
            end
            REGION_2:
            begin
                a = coef(224, 10000) * x0;
                b = coef(31, 1000) * x1;
            end
            REGION_3:
            begin
                a = coef(128, 10000) * x0;
                b = coef(153, 10000) * x1;
            end
            REGION_4:
            begin
                a = coef(146, 100000) * x0;
                b = coef(112, 100000) * x1;
            end
            default: ;
        endcase
        v = '0;
        if (r.band != REGION_NONE && a > b)
        begin
            v = ((a - b) + (64'd1 << (32 - FRAC - 1))) >> (32 - FRAC);
            if (v > 64'(LUX_MAX))
                v = 64'(LUX_MAX);
        end
        r.lux = v[LUX_W-1:0];
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i <= DEPTH; i++)
            power_table[i] = root_entry(i);
    end

    always @(posedge clk)
    begin
        lux_expect_t e;
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
            begin
                lux_expected.push_back(lux_of(sample.broadband_count, sample.infrared_count));
                accepted <= accepted + 1;
            end
            if (result.valid && result.ready)
            begin
                if (lux_expected.size() == 0)
                begin
                    $display("%0t: unexpected result lux=%0d region=%0d", $time,
                             result.lux_value, result.region);
                    errors <= errors + 1;
                end
                else
                begin
                    e = lux_expected.pop_front();
                    band_hits[e.band]++;
                    if (result.lux_value !== e.lux || result.region !== e.band)
                    begin
                        $display("%0t: mismatch expected lux=%0d region=%0d actual lux=%0d region=%0d",
                                 $time, e.lux, e.band, result.lux_value, result.region);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= lux_expected.size();
    end

    initial
    begin
        errors = 0;
        accepted = 0;
        pending = 0;
    end

endmodule

// File: tb/tb_ambient_light_lux_from_two_channels.sv
`timescale 1ns / 1ps

module tb_ambient_light_lux_from_two_channels import alux_pkg::*;;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   accepted;
    int   idle_cycles;
    int   timed_out;

    alux_in_if  sample ();
    alux_out_if result ();

    ambient_light_lux_from_two_channels i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    lux_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample.monitor),
        .result   (result.monitor),
        .errors   (errors),
        .pending  (pending),
        .accepted (accepted)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // hold the request until taken, then, if gaps is set, idle for a random gap
    task automatic send(input logic [15:0] c0, input logic [15:0] c1, input bit gaps);
        int g;
        sample.valid <= 1'b1;
        sample.broadband_count <= c0;
        sample.infrared_count <= c1;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            sample.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic send_random(input bit gaps);
        logic [15:0] c0;
        logic [15:0] c1;
        int          mode;
        mode = $urandom_range(0, 9);
        c0 = 16'($urandom);
        if (mode < 2)
            c0 = 16'($urandom_range(1, 300));
        case (mode % 5)
            0: c1 = 16'($urandom);
            1: c1 = 16'((32'(c0) * $urandom_range(0, 500)) / 1000);
            2: c1 = 16'((32'(c0) * $urandom_range(500, 800)) / 1000);
            3: c1 = 16'((32'(c0) * $urandom_range(800, 1350)) / 1000);
            default: c1 = 16'(32'(c0) / 2 + $urandom_range(0, 2));
        endcase
        send(c0, c1, gaps);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (timed_out == 0 && $urandom_range(0, 99) < 4)
            result.ready <= 1'b0;
        else if (!result.ready && $urandom_range(0, 3) != 0)
            result.ready <= 1'b0;
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        timed_out = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.broadband_count = '0;
        sample.infrared_count = '0;
        result.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(16'd0, 16'd0, 1'b0);
        send(16'd0, 16'hFFFF, 1'b0);
        send(16'hFFFF, 16'd0, 1'b0);
        send(16'hFFFF, 16'd1, 1'b0);
        send(16'hFFFF, 16'h7FFF, 1'b1);
        send(16'hFFFE, 16'h7FFF, 1'b0);
        send(16'd100, 16'd61, 1'b0);
        send(16'd100, 16'd62, 1'b1);
        send(16'd5, 16'd4, 1'b0);
        send(16'd100, 16'd81, 1'b0);
        send(16'd10, 16'd13, 1'b0);
        send(16'd10, 16'd14, 1'b1);
        send(16'hFFFF, 16'hFFFF, 1'b0);
        send(16'd1, 16'd1, 1'b0);
        send(16'd1, 16'hFFFF, 1'b0);
        send(16'hAAAA, 16'h5555, 1'b0);
        send(16'h5555, 16'h2AAA, 1'b1);
        send(16'd2, 16'd1, 1'b0);
        send(16'd3, 16'd1, 1'b0);
        send(16'hFFFF, 16'hC000, 1'b0);

        for (int n = 0; n < 400; n++)
        begin
            send_random(n % 100 >= 30);
            if (n == 200)
            begin
                sample.valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
        end
        sample.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("%0d requests checked; bands none/1/2/3/4: %0d/%0d/%0d/%0d/%0d", accepted,
                 i_checker.band_hits[0], i_checker.band_hits[1], i_checker.band_hits[2],
                 i_checker.band_hits[3], i_checker.band_hits[4]);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
